/* rtl/mdm_pkg.sv */
// ----------------------------------------------------------------------------
// mdm_pkg
// Shared types, widths and helpers for the modulation difference block.
// ----------------------------------------------------------------------------
`default_nettype none

package mdm_pkg;

   localparam int SrcW  = 80;   // serial operand shift register
   localparam int RemW  = 66;   // remainder / product register
   localparam int AccW  = 64;   // quotient / root register
   localparam int StepW = 7;    // step counter, up to 80 steps

   typedef enum logic [1:0] {
      SER_DIV  = 2'd0,
      SER_SQRT = 2'd1,
      SER_MUL  = 2'd2
   } ser_mode_type;

   typedef struct packed {
      logic             start;
      ser_mode_type     mode;
      logic [StepW-1:0] steps;
   } ser_ctrl_type;

   function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction

   function automatic logic [63:0] mul100(input logic [63:0] x);
      return (x << 6) + (x << 5) + (x << 2);
   endfunction

endpackage

`default_nettype wire

/* rtl/mdm_serial.sv */
// ----------------------------------------------------------------------------
// mdm_serial
// Bit-serial arithmetic unit: restoring divide (one quotient bit per cycle),
// square root (one root bit per cycle) and MSB-first shift-add multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module mdm_serial import mdm_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ser_ctrl_type      ctrl,
   input  wire logic [SrcW-1:0]   src_value,
   input  wire logic [AccW-1:0]   operand,
   output logic                   busy,
   output logic [RemW-1:0]        rem,
   output logic [AccW-1:0]        quot,
   output logic                   ovf
);

   logic [SrcW-1:0]  src_ff, src_in;
   logic [RemW-1:0]  rem_ff, rem_in;
   logic [AccW-1:0]  acc_ff, acc_in;
   logic [AccW-1:0]  opnd_ff, opnd_in;
   logic             ovf_ff, ovf_in;
   logic [StepW-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   ser_mode_type     mode_ff, mode_in;

   logic [RemW-1:0]  rsh, trial, diff, addend, prod;
   logic             ge;

   always_comb begin
      if (mode_ff == SER_SQRT) begin
         rsh   = {rem_ff[RemW-3:0], src_ff[SrcW-1 -: 2]};
         trial = {acc_ff, 2'b01};
      end else begin
         rsh   = {rem_ff[RemW-2:0], src_ff[SrcW-1]};
         trial = {2'b00, opnd_ff};
      end
      ge     = (rsh >= trial);
      diff   = rsh - trial;
      addend = src_ff[SrcW-1] ? {2'b00, opnd_ff} : '0;
      prod   = {rem_ff[RemW-2:0], 1'b0} + addend;

      src_in  = src_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      opnd_in = opnd_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      mode_in = mode_ff;

      if (ctrl.start) begin
         src_in  = src_value;
         rem_in  = '0;
         acc_in  = '0;
         opnd_in = operand;
         ovf_in  = 1'b0;
         cnt_in  = ctrl.steps;
         busy_in = 1'b1;
         mode_in = ctrl.mode;
      end else if (busy_ff) begin
         case (mode_ff)
            SER_DIV: begin
               rem_in = ge ? diff : rsh;
               acc_in = {acc_ff[AccW-2:0], ge};
               ovf_in = ovf_ff | acc_ff[AccW-1];
               src_in = src_ff << 1;
            end
            SER_SQRT: begin
               rem_in = ge ? diff : rsh;
               acc_in = {acc_ff[AccW-2:0], ge};
               src_in = src_ff << 2;
            end
            SER_MUL: begin
               rem_in = prod;
               src_in = src_ff << 1;
            end
            default: begin
               rem_in = rem_ff;
            end
         endcase
         cnt_in  = cnt_ff - StepW'(1);
         busy_in = (cnt_ff != StepW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      src_ff  <= src_in;
      rem_ff  <= rem_in;
      acc_ff  <= acc_in;
      opnd_ff <= opnd_in;
      ovf_ff  <= ovf_in;
      mode_ff <= mode_in;
   end

   assign busy = busy_ff;
   assign rem  = rem_ff;
   assign quot = acc_ff;
   assign ovf  = ovf_ff;

endmodule

`default_nettype wire

/* rtl/modulation_difference_mov_top.sv */
// ----------------------------------------------------------------------------
// modulation_difference_mov_top
// Modulation difference output variables: per-band sums, per-frame windowed
// difference and temporally weighted averages.
// ----------------------------------------------------------------------------
// One transaction per band; a result comes out on the last band of a frame.
// The divides, roots and multiplies all go through one bit-serial unit. A
// band runs two 40-step divides, the 48-step weight divide, one band-count
// check and the idle state that accepts the next band. The weight divide is
// skipped when energy and threshold are both zero. A frame's last band then
// runs two band-mean divides, one root per window entry, the mean divide,
// two squarings, the windowed divide and root, two products and two average
// divides before the result loads. Until the window fills, the roots, mean,
// squaring, windowed divide and windowed root are skipped; the two average
// divides are skipped while the weight total is zero. Inputs are held off
// while a transaction is in work; a finished result waits in the output
// register, and a stalled result holds the block in its output state.
`default_nettype none

module modulation_difference_mov_top import mdm_pkg::*; #(
   parameter int WINDOW_LENGTH = 3,
   parameter int MAX_BANDS     = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [23:0] req_mod_test,
   input  wire logic [23:0] req_mod_ref,
   input  wire logic [31:0] req_energy_ref,
   input  wire logic [31:0] req_band_threshold_term,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_windowed_difference,
   output logic [31:0]      rsp_weighted_average_one,
   output logic [31:0]      rsp_weighted_average_two,
   output logic             rsp_window_full,
   output logic             rsp_weight_zero,
   input  wire logic        csr_write_enable,
   input  wire logic [7:0]  csr_write_data
);

   localparam int IdxW   = $clog2(MAX_BANDS);
   localparam int PosW   = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
   localparam int S1W    = 24 + IdxW;
   localparam int S2W    = 31 + IdxW;
   localparam int SwW    = (17 + IdxW > 24) ? 17 + IdxW : 24;
   localparam int RootsW = 24 + $clog2(WINDOW_LENGTH + 1);
   localparam logic [8:0]      MaxBandsC = 9'(MAX_BANDS);
   localparam logic [PosW-1:0] LastPos   = PosW'(WINDOW_LENGTH - 1);

   typedef enum logic [17:0] {
      S_IDLE  = 18'b000000000000000001,
      S_T1    = 18'b000000000000000010,
      S_T2    = 18'b000000000000000100,
      S_TW    = 18'b000000000000001000,
      S_BAND  = 18'b000000000000010000,
      S_MD1   = 18'b000000000000100000,
      S_MD2   = 18'b000000000001000000,
      S_ROOT  = 18'b000000000010000000,
      S_MEAN  = 18'b000000000100000000,
      S_SQ1   = 18'b000000001000000000,
      S_SQ2   = 18'b000000010000000000,
      S_WDIV  = 18'b000000100000000000,
      S_WROOT = 18'b000001000000000000,
      S_P1    = 18'b000010000000000000,
      S_P2    = 18'b000100000000000000,
      S_AV1   = 18'b001000000000000000,
      S_AV2   = 18'b010000000000000000,
      S_OUT   = 18'b100000000000000000
   } state_type;

   state_type         state_ff, state_in;
   logic              issued_ff, issued_in;
   logic [7:0]        band_count_ff, band_count_in;
   logic [IdxW-1:0]   band_index_ff, band_index_in;
   logic [S1W-1:0]    s1_ff, s1_in;
   logic [S2W-1:0]    s2_ff, s2_in;
   logic [SwW-1:0]    sw_ff, sw_in;
   logic [23:0]       d_ff, d_in;
   logic [23:0]       mr_ff, mr_in;
   logic              le_ff, le_in;
   logic [31:0]       er_ff, er_in;
   logic [31:0]       th_ff, th_in;
   logic [31:0]       md1_ff, md1_in;
   logic [39:0]       md2_ff, md2_in;
   logic [23:0]       wsum_ff, wsum_in;
   logic [31:0]       fw_ff [WINDOW_LENGTH];
   logic              fw_we;
   logic [PosW-1:0]   pos_ff, pos_in;
   logic [PosW-1:0]   ridx_ff, ridx_in;
   logic [RootsW-1:0] roots_ff, roots_in;
   logic [31:0]       m_ff, m_in;
   logic [31:0]       frame_count_ff, frame_count_in;
   logic [63:0]       win_acc_ff, win_acc_in;
   logic [63:0]       num1_ff, num1_in;
   logic [63:0]       num2_ff, num2_in;
   logic [63:0]       wt_ff, wt_in;
   logic [31:0]       win_ff, win_in;
   logic [31:0]       avg1_ff, avg1_in;
   logic [31:0]       avg2_ff, avg2_in;
   logic              full_ff, full_in;
   logic              wzero_ff, wzero_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_win_ff, rsp_avg1_ff, rsp_avg2_ff;
   logic              rsp_full_ff, rsp_wzero_ff;
   logic              rsp_load;

   ser_ctrl_type      ser_ctrl;
   logic [SrcW-1:0]   ser_src;
   logic [AccW-1:0]   ser_opnd;
   logic              ser_busy;
   logic [RemW-1:0]   ser_rem;
   logic [AccW-1:0]   ser_quot;
   logic              ser_ovf;

   logic [8:0]        bands_eff;
   logic [28:0]       den2_base, den2;
   logic [63:0]       mul_q, wt_sum;
   logic [47:0]       wq_cap;
   logic              fin;

   mdm_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ser_ctrl),
      .src_value (ser_src),
      .operand   (ser_opnd),
      .busy      (ser_busy),
      .rem       (ser_rem),
      .quot      (ser_quot),
      .ovf       (ser_ovf)
   );

   always_comb begin
      if (band_count_ff == 8'd0) begin
         bands_eff = 9'd1;
      end else if ({1'b0, band_count_ff} > MaxBandsC) begin
         bands_eff = MaxBandsC;
      end else begin
         bands_eff = {1'b0, band_count_ff};
      end
      den2_base = 29'(mr_ff) + 29'd655;
      den2      = le_ff ? (den2_base << 3) + (den2_base << 1) : den2_base;
      mul_q     = mul100(ser_quot);
      wq_cap    = (|ser_quot[63:48]) ? {48{1'b1}} : ser_quot[47:0];
      wt_sum    = sat_add64(wt_ff, 64'(wsum_ff));
      fin       = issued_ff && !ser_busy;
   end

   always_comb begin
      state_in       = state_ff;
      issued_in      = issued_ff;
      band_count_in  = band_count_ff;
      band_index_in  = band_index_ff;
      s1_in          = s1_ff;
      s2_in          = s2_ff;
      sw_in          = sw_ff;
      d_in           = d_ff;
      mr_in          = mr_ff;
      le_in          = le_ff;
      er_in          = er_ff;
      th_in          = th_ff;
      md1_in         = md1_ff;
      md2_in         = md2_ff;
      wsum_in        = wsum_ff;
      fw_we          = 1'b0;
      pos_in         = pos_ff;
      ridx_in        = ridx_ff;
      roots_in       = roots_ff;
      m_in           = m_ff;
      frame_count_in = frame_count_ff;
      win_acc_in     = win_acc_ff;
      num1_in        = num1_ff;
      num2_in        = num2_ff;
      wt_in          = wt_ff;
      win_in         = win_ff;
      avg1_in        = avg1_ff;
      avg2_in        = avg2_ff;
      full_in        = full_ff;
      wzero_in       = wzero_ff;
      rsp_load       = 1'b0;
      ser_ctrl.start = 1'b0;
      ser_ctrl.mode  = SER_DIV;
      ser_ctrl.steps = StepW'(64);
      ser_src        = '0;
      ser_opnd       = '0;

      if (csr_write_enable) begin
         band_count_in = csr_write_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               d_in     = (req_mod_test > req_mod_ref) ? req_mod_test - req_mod_ref
                                                       : req_mod_ref - req_mod_test;
               mr_in    = req_mod_ref;
               le_in    = (req_mod_test <= req_mod_ref);
               er_in    = req_energy_ref;
               th_in    = req_band_threshold_term;
               state_in = S_T1;
            end
         end
         S_T1: begin
            ser_src  = {d_ff, 16'b0, 40'b0};
            ser_opnd = 64'(mr_ff) + 64'd65536;
            ser_ctrl.steps = StepW'(40);
            if (!issued_ff) begin
               ser_ctrl.start = 1'b1;
               issued_in      = 1'b1;
            end else if (fin) begin
               s1_in     = s1_ff + S1W'(ser_quot[23:0]);
               issued_in = 1'b0;
               state_in  = S_T2;
            end
         end
         S_T2: begin
            ser_src  = {d_ff, 16'b0, 40'b0};
            ser_opnd = 64'(den2);
            ser_ctrl.steps = StepW'(40);
            if (!issued_ff) begin
               ser_ctrl.start = 1'b1;
               issued_in      = 1'b1;
            end else if (fin) begin
               s2_in     = s2_ff + S2W'(ser_quot[30:0]);
               issued_in = 1'b0;
               state_in  = S_TW;
            end
         end
         S_TW: begin
            ser_src  = {er_ff, 16'b0, 32'b0};
            ser_opnd = 64'(er_ff) + 64'(th_ff);
            ser_ctrl.steps = StepW'(48);
            if (!issued_ff) begin
               if (ser_opnd == 64'd0) begin
                  state_in = S_BAND;
               end else begin
                  ser_ctrl.start = 1'b1;
                  issued_in      = 1'b1;
               end
            end else if (fin) begin
               sw_in     = sw_ff + SwW'(ser_quot[16:0]);
               issued_in = 1'b0;
               state_in  = S_BAND;
            end
         end
         S_BAND: begin
            if (9'(band_index_ff) + 9'd1 < bands_eff) begin
               band_index_in = band_index_ff + IdxW'(1);
               state_in      = S_IDLE;
            end else begin
               state_in = S_MD1;
            end
         end
         S_MD1: begin
            ser_src  = {64'(s1_ff), 16'b0};
            ser_opnd = 64'(bands_eff);
            if (!issued_ff) begin
               ser_ctrl.start = 1'b1;
               issued_in      = 1'b1;
            end else if (fin) begin
               md1_in    = (|mul_q[63:32]) ? 32'hFFFF_FFFF : mul_q[31:0];
               issued_in = 1'b0;
               state_in  = S_MD2;
            end
         end
         S_MD2: begin
            ser_src  = {64'(s2_ff), 16'b0};
            ser_opnd = 64'(bands_eff);
            if (!issued_ff) begin
               ser_ctrl.start = 1'b1;
               issued_in      = 1'b1;
            end else if (fin) begin
               md2_in        = (|mul_q[63:40]) ? {40{1'b1}} : mul_q[39:0];
               wsum_in       = (64'(sw_ff) > 64'h00FF_FFFF) ? 24'hFF_FFFF : sw_ff[23:0];
               s1_in         = '0;
               s2_in         = '0;
               sw_in         = '0;
               band_index_in = '0;
               fw_we         = 1'b1;
               pos_in        = (pos_ff == LastPos) ? '0 : pos_ff + PosW'(1);
               issued_in     = 1'b0;
               ridx_in       = '0;
               roots_in      = '0;
               if (frame_count_ff >= 32'(WINDOW_LENGTH)) begin
                  full_in  = 1'b1;
                  state_in = S_ROOT;
               end else begin
                  full_in  = 1'b0;
                  win_in   = '0;
                  state_in = S_P1;
               end
            end
         end
         S_ROOT: begin
            ser_src       = {16'b0, fw_ff[ridx_ff], 16'b0, 16'b0};
            ser_ctrl.mode = SER_SQRT;
            ser_ctrl.steps = StepW'(32);
            if (!issued_ff) begin
               ser_ctrl.start = 1'b1;
               issued_in      = 1'b1;
            end else if (fin) begin
               roots_in  = roots_ff + RootsW'(ser_quot[23:0]);
               issued_in = 1'b0;
               if (ridx_ff == LastPos) begin
                  state_in = S_MEAN;
               end else begin
                  ridx_in = ridx_ff + PosW'(1);
               end
            end
         end
         S_MEAN: begin
            ser_src  = {64'(roots_ff), 16'b0};
            ser_opnd = 64'(WINDOW_LENGTH);
            if (!issued_ff) begin
               ser_ctrl.start = 1'b1;
               issued_in      = 1'b1;
            end else if (fin) begin
               m_in      = 32'(ser_quot[23:0]);
               issued_in = 1'b0;
               state_in  = S_SQ1;
            end
         end
         S_SQ1: begin
            ser_src       = {32'b0, m_ff, 16'b0};
            ser_opnd      = 64'(m_ff);
            ser_ctrl.mode = SER_MUL;
            if (!issued_ff) begin
               ser_ctrl.start = 1'b1;
               issued_in      = 1'b1;
            end else if (fin) begin
               m_in      = ser_rem[47:16];
               issued_in = 1'b0;
               state_in  = S_SQ2;
            end
         end
         S_SQ2: begin
            ser_src       = {32'b0, m_ff, 16'b0};
            ser_opnd      = 64'(m_ff);
            ser_ctrl.mode = SER_MUL;
            if (!issued_ff) begin
               ser_ctrl.start = 1'b1;
               issued_in      = 1'b1;
            end else if (fin) begin
               win_acc_in = sat_add64(win_acc_ff, 64'(ser_rem[63:16]));
               issued_in  = 1'b0;
               state_in   = S_WDIV;
            end
         end
         S_WDIV: begin
            ser_src  = {win_acc_ff, 16'b0};
            ser_opnd = 64'(frame_count_ff) - 64'(WINDOW_LENGTH - 1);
            if (!issued_ff) begin
               ser_ctrl.start = 1'b1;
               issued_in      = 1'b1;
            end else if (fin) begin
               issued_in = 1'b0;
               state_in  = S_WROOT;
            end
         end
         S_WROOT: begin
            // quotient of the previous divide is still held in the unit
            ser_src        = {wq_cap, 16'b0, 16'b0};
            ser_ctrl.mode  = SER_SQRT;
            ser_ctrl.steps = StepW'(32);
            if (!issued_ff) begin
               ser_ctrl.start = 1'b1;
               issued_in      = 1'b1;
            end else if (fin) begin
               win_in    = ser_quot[31:0];
               issued_in = 1'b0;
               state_in  = S_P1;
            end
         end
         S_P1: begin
            ser_src       = {40'b0, wsum_ff, 16'b0};
            ser_opnd      = 64'(md1_ff);
            ser_ctrl.mode = SER_MUL;
            if (!issued_ff) begin
               ser_ctrl.start = 1'b1;
               issued_in      = 1'b1;
               if (frame_count_ff != 32'hFFFF_FFFF) begin
                  frame_count_in = frame_count_ff + 32'd1;
               end
            end else if (fin) begin
               num1_in   = sat_add64(num1_ff, 64'(ser_rem[63:16]));
               issued_in = 1'b0;
               state_in  = S_P2;
            end
         end
         S_P2: begin
            ser_src       = {40'b0, wsum_ff, 16'b0};
            ser_opnd      = 64'(md2_ff);
            ser_ctrl.mode = SER_MUL;
            if (!issued_ff) begin
               ser_ctrl.start = 1'b1;
               issued_in      = 1'b1;
            end else if (fin) begin
               num2_in   = sat_add64(num2_ff, 64'(ser_rem[63:16]));
               wt_in     = wt_sum;
               issued_in = 1'b0;
               if (wt_sum == 64'd0) begin
                  avg1_in  = '0;
                  avg2_in  = '0;
                  wzero_in = 1'b1;
                  state_in = S_OUT;
               end else begin
                  wzero_in = 1'b0;
                  state_in = S_AV1;
               end
            end
         end
         S_AV1: begin
            ser_src        = {num1_ff, 16'b0};
            ser_opnd       = wt_ff;
            ser_ctrl.steps = StepW'(80);
            if (!issued_ff) begin
               ser_ctrl.start = 1'b1;
               issued_in      = 1'b1;
            end else if (fin) begin
               avg1_in   = (ser_ovf || (|ser_quot[63:32])) ? 32'hFFFF_FFFF : ser_quot[31:0];
               issued_in = 1'b0;
               state_in  = S_AV2;
            end
         end
         S_AV2: begin
            ser_src        = {num2_ff, 16'b0};
            ser_opnd       = wt_ff;
            ser_ctrl.steps = StepW'(80);
            if (!issued_ff) begin
               ser_ctrl.start = 1'b1;
               issued_in      = 1'b1;
            end else if (fin) begin
               avg2_in   = (ser_ovf || (|ser_quot[63:32])) ? 32'hFFFF_FFFF : ser_quot[31:0];
               issued_in = 1'b0;
               state_in  = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in  = S_IDLE;
            issued_in = 1'b0;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         issued_ff      <= 1'b0;
         band_count_ff  <= 8'd109;
         band_index_ff  <= '0;
         s1_ff          <= '0;
         s2_ff          <= '0;
         sw_ff          <= '0;
         pos_ff         <= '0;
         frame_count_ff <= '0;
         win_acc_ff     <= '0;
         num1_ff        <= '0;
         num2_ff        <= '0;
         wt_ff          <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         issued_ff      <= issued_in;
         band_count_ff  <= band_count_in;
         band_index_ff  <= band_index_in;
         s1_ff          <= s1_in;
         s2_ff          <= s2_in;
         sw_ff          <= sw_in;
         pos_ff         <= pos_in;
         frame_count_ff <= frame_count_in;
         win_acc_ff     <= win_acc_in;
         num1_ff        <= num1_in;
         num2_ff        <= num2_in;
         wt_ff          <= wt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      d_ff     <= d_in;
      mr_ff    <= mr_in;
      le_ff    <= le_in;
      er_ff    <= er_in;
      th_ff    <= th_in;
      md1_ff   <= md1_in;
      md2_ff   <= md2_in;
      wsum_ff  <= wsum_in;
      ridx_ff  <= ridx_in;
      roots_ff <= roots_in;
      m_ff     <= m_in;
      win_ff   <= win_in;
      avg1_ff  <= avg1_in;
      avg2_ff  <= avg2_in;
      full_ff  <= full_in;
      wzero_ff <= wzero_in;
      if (rsp_load) begin
         rsp_win_ff   <= win_ff;
         rsp_avg1_ff  <= avg1_ff;
         rsp_avg2_ff  <= avg2_ff;
         rsp_full_ff  <= full_ff;
         rsp_wzero_ff <= wzero_ff;
      end
   end

   // window entries reset to zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_LENGTH; i++) begin
            fw_ff[i] <= '0;
         end
      end else if (fw_we) begin
         fw_ff[pos_ff] <= md1_ff;
      end
   end

   assign req_stall                = (state_ff != S_IDLE);
   assign rsp_valid                = rsp_valid_ff;
   assign rsp_windowed_difference  = rsp_win_ff;
   assign rsp_weighted_average_one = rsp_avg1_ff;
   assign rsp_weighted_average_two = rsp_avg2_ff;
   assign rsp_window_full          = rsp_full_ff;
   assign rsp_weight_zero          = rsp_wzero_ff;

   a_idle_unit_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !ser_busy)
      else $error("serial unit busy while idle");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == S_OUT))
      else $error("result raised outside output state");

   a_not_full_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_window_full) |-> (rsp_windowed_difference == 32'd0))
      else $error("windowed difference nonzero before window fills");

   a_wzero_avgs: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_weight_zero) |->
         (rsp_weighted_average_one == 32'd0 && rsp_weighted_average_two == 32'd0))
      else $error("averages nonzero with zero weight");

endmodule

`default_nettype wire
